/* hw/rtl/tpg_pkg.sv */
`default_nettype none

package tpg_pkg;

  // Field and state widths
  localparam int POS_WIDTH      = 32;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int OUT_WIDTH      = 32;
  localparam int ORIGIN_WIDTH   = 32;
  localparam int SYM_WIDTH      = 8;
  localparam int HEAD_WIDTH     = 11;
  localparam int HEXT_WIDTH     = HEAD_WIDTH + 1;
  localparam int COUNT_WIDTH    = 16;
  localparam int STEP_WIDTH     = 16;
  localparam int TURN_WIDTH     = 9;
  localparam int LIMIT_WIDTH    = 16;
  localparam int MASK_WIDTH     = 64;
  localparam int MASK_IDX_WIDTH = $clog2(MASK_WIDTH);
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 64;

  // Angles in whole degrees
  localparam int FULL_TURN    = 360;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;
  localparam int ANGLE_WIDTH  = $clog2(FULL_TURN);

  // Quarter-wave tables and datapath widths
  localparam int QTAB_DEPTH  = QUARTER_TURN + 1;
  localparam int QIDX_WIDTH  = $clog2(QTAB_DEPTH);
  localparam int MAG_WIDTH   = TRIG_FRAC_BITS + 1;
  localparam int TRIG_WIDTH  = TRIG_FRAC_BITS + 2;
  localparam int PROD_WIDTH  = TRIG_WIDTH + STEP_WIDTH + 1;
  localparam int DELTA_WIDTH = PROD_WIDTH - TRIG_FRAC_BITS;
  localparam int RSUM_WIDTH  = (POS_WIDTH > DELTA_WIDTH ? POS_WIDTH : DELTA_WIDTH) + 1;
  localparam int OSUM_WIDTH  = (POS_WIDTH > ORIGIN_WIDTH ? POS_WIDTH : ORIGIN_WIDTH) + 1;

  // Symbol codes
  localparam logic [SYM_WIDTH-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_WIDTH-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_WIDTH-1:0] SYM_BAR   = 8'h7C;
  localparam logic [SYM_WIDTH-1:0] SYM_FWD   = 8'h46;
  localparam logic [SYM_WIDTH-1:0] SYM_BACK  = 8'h42;
  localparam logic [SYM_WIDTH-1:0] SYM_DOT   = 8'h2E;
  localparam logic [1:0]           SYM_MASK_PAGE = 2'b01;

  // Config register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TURN_STEP    = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ORIGIN_X     = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ORIGIN_Y     = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SYMBOL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FORWARD_MASK = 3'd5;

  typedef struct packed {
    logic        [STEP_WIDTH-1:0]   step_length;
    logic        [TURN_WIDTH-1:0]   turn_step;
    logic signed [ORIGIN_WIDTH-1:0] origin_x;
    logic signed [ORIGIN_WIDTH-1:0] origin_y;
    logic        [LIMIT_WIDTH-1:0]  symbol_limit;
    logic        [MASK_WIDTH-1:0]   forward_mask;
  } cfg_t;

  // Heading stage -> trig stage
  typedef struct packed {
    logic                         mv;
    logic                         pen;
    logic                         bwd;
    logic                         clr;
    logic signed [HEAD_WIDTH-1:0] head;
  } head_cmd_t;

  // Trig stage -> move stage
  typedef struct packed {
    logic                         mv;
    logic                         pen;
    logic                         clr;
    logic signed [TRIG_WIDTH-1:0] cx;
    logic signed [TRIG_WIDTH-1:0] cy;
  } trig_cmd_t;

  typedef logic [QTAB_DEPTH-1:0][MAG_WIDTH-1:0] qtab_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] DEG_Q30 = 64'd18740330;

  // Taylor series in Q30, truncating products and divisions.
  // Terms past the last nonzero one stay zero.
  function automatic logic [63:0] series_q30(input logic [63:0] x, input logic want_cos);
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] acc;
    x2 = (x * x) >> 30;
    if (want_cos) begin
      t   = Q30_ONE;
      acc = $signed(Q30_ONE);
      t = ((t * x2) >> 30) / 2;   acc = acc - $signed(t);
      t = ((t * x2) >> 30) / 12;  acc = acc + $signed(t);
      t = ((t * x2) >> 30) / 30;  acc = acc - $signed(t);
      t = ((t * x2) >> 30) / 56;  acc = acc + $signed(t);
      t = ((t * x2) >> 30) / 90;  acc = acc - $signed(t);
      t = ((t * x2) >> 30) / 132; acc = acc + $signed(t);
      t = ((t * x2) >> 30) / 182; acc = acc - $signed(t);
      t = ((t * x2) >> 30) / 240; acc = acc + $signed(t);
    end else begin
      t   = x;
      acc = $signed(x);
      t = ((t * x2) >> 30) / 6;   acc = acc - $signed(t);
      t = ((t * x2) >> 30) / 20;  acc = acc + $signed(t);
      t = ((t * x2) >> 30) / 42;  acc = acc - $signed(t);
      t = ((t * x2) >> 30) / 72;  acc = acc + $signed(t);
      t = ((t * x2) >> 30) / 110; acc = acc - $signed(t);
      t = ((t * x2) >> 30) / 156; acc = acc + $signed(t);
      t = ((t * x2) >> 30) / 210; acc = acc - $signed(t);
      t = ((t * x2) >> 30) / 272; acc = acc + $signed(t);
    end
    return (acc < 0) ? 64'd0 : $unsigned(acc);
  endfunction

  // Q30 magnitude rounded half up to Q(TRIG_FRAC_BITS)
  function automatic logic [MAG_WIDTH-1:0] q30_to_mag(input logic [63:0] mag);
    logic [63:0] r;
    r = (mag + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return r[MAG_WIDTH-1:0];
  endfunction

  // First-quadrant magnitudes, 0..90 degrees. Mirror fill at 45 degrees
  // overwrites in the same order as the series sweep.
  function automatic qtab_t build_qtab(input logic want_cos);
    logic [63:0] qs [QTAB_DEPTH];
    logic [63:0] qc [QTAB_DEPTH];
    logic [63:0] s;
    logic [63:0] c;
    qtab_t       tab;
    for (int k = 0; k <= QUARTER_TURN / 2; k++) begin
      s = series_q30(64'(k) * DEG_Q30, 1'b0);
      c = series_q30(64'(k) * DEG_Q30, 1'b1);
      qs[k] = s;
      qc[k] = c;
      qs[QUARTER_TURN - k] = c;
      qc[QUARTER_TURN - k] = s;
    end
    for (int k = 0; k < QTAB_DEPTH; k++) begin
      tab[k] = q30_to_mag(want_cos ? qc[k] : qs[k]);
    end
    return tab;
  endfunction

  localparam qtab_t QCOS_TAB = build_qtab(1'b1);
  localparam qtab_t QSIN_TAB = build_qtab(1'b0);

endpackage

`default_nettype wire

/* hw/rtl/tpg_ctrl.sv */
`default_nettype none

module tpg_ctrl import tpg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SYM_WIDTH-1:0] symbol_i,
  input  logic                 first_i,
  output logic                 a_valid_o,
  input  logic                 a_ready_i,
  output head_cmd_t            a_cmd_o
);

  localparam logic signed [HEXT_WIDTH-1:0] FULL_X = HEXT_WIDTH'(FULL_TURN);
  localparam logic signed [HEXT_WIDTH-1:0] HALF_X = HEXT_WIDTH'(HALF_TURN);
  localparam logic [TURN_WIDTH-1:0]        TURN_MAX = TURN_WIDTH'(FULL_TURN);

  logic signed [HEAD_WIDTH-1:0] head_q, head_d, head_base;
  logic [COUNT_WIDTH-1:0]       cnt_q, cnt_d, cnt_base;
  logic                         a_vld_q;
  head_cmd_t                    a_cmd_q;

  logic                         a_ready, accept, limited;
  logic [TURN_WIDTH-1:0]        turn;
  logic signed [HEXT_WIDTH-1:0] head_x, turn_x, head_t;
  logic                         move_sym, mask_hit, do_move;

  assign a_ready    = !a_vld_q || a_ready_i;
  assign in_stall_o = !a_ready;
  assign accept     = in_valid_i && a_ready;

  assign head_base = first_i ? '0 : head_q;
  assign cnt_base  = first_i ? '0 : cnt_q;
  assign limited   = cnt_base >= cfg_i.symbol_limit;
  assign turn      = (cfg_i.turn_step > TURN_MAX) ? TURN_MAX : cfg_i.turn_step;
  assign head_x    = HEXT_WIDTH'(head_base);
  assign turn_x    = $signed(HEXT_WIDTH'(turn));

  always_comb begin
    head_t = head_x;
    case (symbol_i)
      SYM_PLUS: begin
        head_t = head_x + turn_x;
        if (head_t > FULL_X) head_t = head_t - FULL_X;
      end
      SYM_MINUS: begin
        head_t = head_x - turn_x;
        if (head_t < -FULL_X) head_t = head_t + FULL_X;
      end
      SYM_BAR: begin
        head_t = head_x + HALF_X;
        if (head_t > FULL_X) head_t = head_t - FULL_X;
      end
      default: head_t = head_x;
    endcase
  end

  assign move_sym = (symbol_i == SYM_FWD) || (symbol_i == SYM_BACK) || (symbol_i == SYM_DOT);
  assign mask_hit = !move_sym && (symbol_i[SYM_WIDTH-1 -: 2] == SYM_MASK_PAGE) &&
                    cfg_i.forward_mask[symbol_i[MASK_IDX_WIDTH-1:0]];
  assign do_move  = !limited && (move_sym || mask_hit);

  assign head_d = limited ? head_base : HEAD_WIDTH'(head_t);
  assign cnt_d  = limited ? cnt_base : cnt_base + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      cnt_q   <= '0;
      a_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q <= head_d;
        cnt_q  <= cnt_d;
      end
      if (a_ready) a_vld_q <= accept && (do_move || first_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_cmd_q.mv   <= do_move;
      a_cmd_q.pen  <= symbol_i != SYM_DOT;
      a_cmd_q.bwd  <= symbol_i == SYM_BACK;
      a_cmd_q.clr  <= first_i;
      a_cmd_q.head <= head_d;
    end
  end

  assign a_valid_o = a_vld_q;
  assign a_cmd_o   = a_cmd_q;

endmodule

`default_nettype wire

/* hw/rtl/tpg_trig.sv */
`default_nettype none

module tpg_trig import tpg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      a_valid_i,
  output logic      a_ready_o,
  input  head_cmd_t a_cmd_i,
  output logic      b_valid_o,
  input  logic      b_ready_i,
  output trig_cmd_t b_cmd_o
);

  localparam logic signed [HEAD_WIDTH-1:0] FULL_H = HEAD_WIDTH'(FULL_TURN);
  localparam logic [ANGLE_WIDTH-1:0] A360 = ANGLE_WIDTH'(FULL_TURN);
  localparam logic [ANGLE_WIDTH-1:0] A90  = ANGLE_WIDTH'(QUARTER_TURN);
  localparam logic [ANGLE_WIDTH-1:0] A180 = ANGLE_WIDTH'(HALF_TURN);
  localparam logic [ANGLE_WIDTH-1:0] A270 = ANGLE_WIDTH'(HALF_TURN + QUARTER_TURN);

  logic                         b_vld_q;
  trig_cmd_t                    b_cmd_q;
  logic                         b_ready;
  logic signed [HEAD_WIDTH-1:0] head_w;
  logic [ANGLE_WIDTH-1:0]       ang, idx, base;
  logic [QIDX_WIDTH-1:0]        r;
  logic                         swap, neg_c, neg_s;
  logic [MAG_WIDTH-1:0]         mag_c, mag_s;
  logic signed [TRIG_WIDTH-1:0] pos_c, pos_s;

  assign b_ready   = !b_vld_q || b_ready_i;
  assign a_ready_o = b_ready;

  // Table angle 0..359
  assign head_w = (a_cmd_i.head < 0) ? a_cmd_i.head + FULL_H : a_cmd_i.head;
  assign ang    = ANGLE_WIDTH'(head_w);
  assign idx    = (ang == A360) ? '0 : ang;

  always_comb begin
    if (idx >= A270) begin
      base = A270; swap = 1'b1; neg_c = 1'b0; neg_s = 1'b1;
    end else if (idx >= A180) begin
      base = A180; swap = 1'b0; neg_c = 1'b1; neg_s = 1'b1;
    end else if (idx >= A90) begin
      base = A90;  swap = 1'b1; neg_c = 1'b1; neg_s = 1'b0;
    end else begin
      base = '0;   swap = 1'b0; neg_c = 1'b0; neg_s = 1'b0;
    end
  end

  assign r     = QIDX_WIDTH'(idx - base);
  assign mag_c = swap ? QSIN_TAB[r] : QCOS_TAB[r];
  assign mag_s = swap ? QCOS_TAB[r] : QSIN_TAB[r];
  assign pos_c = $signed(TRIG_WIDTH'(mag_c));
  assign pos_s = $signed(TRIG_WIDTH'(mag_s));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_ready) begin
      b_vld_q <= a_valid_i;
    end
  end

  // Backward moves negate the direction; product rounding is symmetric
  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_cmd_q.mv  <= a_cmd_i.mv;
      b_cmd_q.pen <= a_cmd_i.pen;
      b_cmd_q.clr <= a_cmd_i.clr;
      b_cmd_q.cx  <= (neg_c ^ a_cmd_i.bwd) ? -pos_c : pos_c;
      b_cmd_q.cy  <= (neg_s ^ a_cmd_i.bwd) ? -pos_s : pos_s;
    end
  end

  assign b_valid_o = b_vld_q;
  assign b_cmd_o   = b_cmd_q;

endmodule

`default_nettype wire

/* hw/rtl/tpg_move.sv */
`default_nettype none

module tpg_move import tpg_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [STEP_WIDTH-1:0]          step_length_i,
  input  logic signed [ORIGIN_WIDTH-1:0] origin_x_i,
  input  logic signed [ORIGIN_WIDTH-1:0] origin_y_i,
  input  logic                           b_valid_i,
  output logic                           b_ready_o,
  input  trig_cmd_t                      b_cmd_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pen_down_o,
  output logic signed [OUT_WIDTH-1:0]    point_x_o,
  output logic signed [OUT_WIDTH-1:0]    point_y_o
);

  localparam logic signed [PROD_WIDTH-1:0] HALF_LSB =
    PROD_WIDTH'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [RSUM_WIDTH-1:0] POS_MAX =
    RSUM_WIDTH'({1'b0, {(POS_WIDTH-1){1'b1}}});
  localparam logic signed [RSUM_WIDTH-1:0] POS_MIN = ~POS_MAX;
  localparam logic signed [OSUM_WIDTH-1:0] OUT_MAX =
    OSUM_WIDTH'({1'b0, {(OUT_WIDTH-1){1'b1}}});
  localparam logic signed [OSUM_WIDTH-1:0] OUT_MIN = ~OUT_MAX;

  // product stage
  logic                         c_vld_q, c_mv_q, c_pen_q, c_clr_q;
  logic signed [PROD_WIDTH-1:0] c_px_q, c_py_q;
  // position stage
  logic                         d_vld_q, d_pen_q;
  logic signed [POS_WIDTH-1:0]  d_rx_q, d_ry_q;
  logic signed [POS_WIDTH-1:0]  rel_x_q, rel_y_q;
  // result register
  logic                         out_vld_q, pen_q;
  logic signed [OUT_WIDTH-1:0]  px_q, py_q;

  logic                          out_ready, d_ready, c_ready, c_step;
  logic signed [PROD_WIDTH-1:0]  step_s, prod_x, prod_y;
  logic signed [PROD_WIDTH-1:0]  rnd_x, rnd_y;
  logic signed [DELTA_WIDTH-1:0] dx, dy;
  logic signed [POS_WIDTH-1:0]   base_x, base_y, new_x, new_y;
  logic signed [RSUM_WIDTH-1:0]  sum_x, sum_y;
  logic signed [OSUM_WIDTH-1:0]  osum_x, osum_y;

  assign out_ready = !out_vld_q || !out_stall_i;
  assign d_ready   = !d_vld_q || out_ready;
  assign c_ready   = !c_vld_q || d_ready;
  assign c_step    = c_vld_q && d_ready;
  assign b_ready_o = c_ready;

  assign step_s = $signed(PROD_WIDTH'(step_length_i));
  assign prod_x = PROD_WIDTH'(b_cmd_i.cx) * step_s;
  assign prod_y = PROD_WIDTH'(b_cmd_i.cy) * step_s;

  // Round half away from zero: negative values add one less before the shift
  assign rnd_x = c_px_q + (c_px_q < 0 ? HALF_LSB - 1 : HALF_LSB);
  assign rnd_y = c_py_q + (c_py_q < 0 ? HALF_LSB - 1 : HALF_LSB);
  assign dx    = DELTA_WIDTH'(rnd_x >>> TRIG_FRAC_BITS);
  assign dy    = DELTA_WIDTH'(rnd_y >>> TRIG_FRAC_BITS);

  assign base_x = c_clr_q ? '0 : rel_x_q;
  assign base_y = c_clr_q ? '0 : rel_y_q;
  assign sum_x  = RSUM_WIDTH'(base_x) + RSUM_WIDTH'(dx);
  assign sum_y  = RSUM_WIDTH'(base_y) + RSUM_WIDTH'(dy);

  always_comb begin
    if (!c_mv_q)             new_x = base_x;
    else if (sum_x > POS_MAX) new_x = POS_MAX[POS_WIDTH-1:0];
    else if (sum_x < POS_MIN) new_x = POS_MIN[POS_WIDTH-1:0];
    else                     new_x = sum_x[POS_WIDTH-1:0];
    if (!c_mv_q)             new_y = base_y;
    else if (sum_y > POS_MAX) new_y = POS_MAX[POS_WIDTH-1:0];
    else if (sum_y < POS_MIN) new_y = POS_MIN[POS_WIDTH-1:0];
    else                     new_y = sum_y[POS_WIDTH-1:0];
  end

  assign osum_x = OSUM_WIDTH'(d_rx_q) + OSUM_WIDTH'(origin_x_i);
  assign osum_y = OSUM_WIDTH'(d_ry_q) + OSUM_WIDTH'(origin_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      rel_x_q   <= '0;
      rel_y_q   <= '0;
    end else begin
      if (c_ready)   c_vld_q   <= b_valid_i;
      if (d_ready)   d_vld_q   <= c_vld_q && c_mv_q;
      if (out_ready) out_vld_q <= d_vld_q;
      if (c_step) begin
        rel_x_q <= new_x;
        rel_y_q <= new_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready) begin
      c_mv_q  <= b_cmd_i.mv;
      c_pen_q <= b_cmd_i.pen;
      c_clr_q <= b_cmd_i.clr;
      c_px_q  <= prod_x;
      c_py_q  <= prod_y;
    end
    if (d_ready) begin
      d_pen_q <= c_pen_q;
      d_rx_q  <= new_x;
      d_ry_q  <= new_y;
    end
    if (out_ready) begin
      pen_q <= d_pen_q;
      if (osum_x > OUT_MAX)      px_q <= OUT_MAX[OUT_WIDTH-1:0];
      else if (osum_x < OUT_MIN) px_q <= OUT_MIN[OUT_WIDTH-1:0];
      else                       px_q <= osum_x[OUT_WIDTH-1:0];
      if (osum_y > OUT_MAX)      py_q <= OUT_MAX[OUT_WIDTH-1:0];
      else if (osum_y < OUT_MIN) py_q <= OUT_MIN[OUT_WIDTH-1:0];
      else                       py_q <= osum_y[OUT_WIDTH-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign pen_down_o  = pen_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;

endmodule

`default_nettype wire

/* hw/rtl/turtle_path_generator_top.sv */
// Turtle path generator: one L-system symbol per transfer, one point per move.
// A move symbol goes through the stage A, B, C, D and result registers.
// Throughput: one symbol per cycle while the output is not stalled; the
// heading and position recurrences each close within a single register stage.
// Reset: config registers take their documented defaults, heading, position
// and count clear, the pipeline empties. No clearing pass is needed.
`default_nettype none

module turtle_path_generator_top import tpg_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]      cfg_data_i,
  // symbol input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [SYM_WIDTH-1:0]           symbol_i,
  input  logic                           first_i,
  // point output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pen_down_o,
  output logic signed [OUT_WIDTH-1:0]    point_x_o,
  output logic signed [OUT_WIDTH-1:0]    point_y_o
);

  // Pipeline:
  //   ctrl : symbol decode, heading and count update at the transfer,
  //          registers the move command (stage A)
  //   trig : heading -> table angle, quarter-wave lookup, sign/backward
  //          handling (stage B)
  //   move : step multiply (C), rounding + relative position update with
  //          saturation (D), origin add and output saturation (result reg)
  // Each stage is released by a ready chained back from the output,
  // so bubbles collapse and the input keeps taking symbols while a point
  // waits on a stalled output, as long as a stage ahead of it is empty.
  // Non-move symbols leave the pipeline after stage A, except a symbol with
  // first set, which rides down to clear the relative position in order.

  cfg_t      cfg_q;
  logic      a_valid, a_ready;
  head_cmd_t a_cmd;
  logic      b_valid, b_ready;
  trig_cmd_t b_cmd;

  // Config registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_length  <= STEP_WIDTH'(2560);
      cfg_q.turn_step    <= TURN_WIDTH'(90);
      cfg_q.origin_x     <= '0;
      cfg_q.origin_y     <= '0;
      cfg_q.symbol_limit <= '1;
      cfg_q.forward_mask <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP_LENGTH:  cfg_q.step_length  <= cfg_data_i[STEP_WIDTH-1:0];
        CFG_TURN_STEP:    cfg_q.turn_step    <= cfg_data_i[TURN_WIDTH-1:0];
        CFG_ORIGIN_X:     cfg_q.origin_x     <= $signed(cfg_data_i[ORIGIN_WIDTH-1:0]);
        CFG_ORIGIN_Y:     cfg_q.origin_y     <= $signed(cfg_data_i[ORIGIN_WIDTH-1:0]);
        CFG_SYMBOL_LIMIT: cfg_q.symbol_limit <= cfg_data_i[LIMIT_WIDTH-1:0];
        CFG_FORWARD_MASK: cfg_q.forward_mask <= cfg_data_i[MASK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  tpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .symbol_i   (symbol_i),
    .first_i    (first_i),
    .a_valid_o  (a_valid),
    .a_ready_i  (a_ready),
    .a_cmd_o    (a_cmd)
  );

  tpg_trig u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .a_valid_i (a_valid),
    .a_ready_o (a_ready),
    .a_cmd_i   (a_cmd),
    .b_valid_o (b_valid),
    .b_ready_i (b_ready),
    .b_cmd_o   (b_cmd)
  );

  tpg_move u_move (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_length_i (cfg_q.step_length),
    .origin_x_i    (cfg_q.origin_x),
    .origin_y_i    (cfg_q.origin_y),
    .b_valid_i     (b_valid),
    .b_ready_o     (b_ready),
    .b_cmd_i       (b_cmd),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pen_down_o    (pen_down_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o)
  );

endmodule

`default_nettype wire

/* tb/turtle_checker.sv */
`timescale 1ns / 100ps

module turtle_checker import tpg_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [SYM_WIDTH-1:0]          symbol_i,
  input  logic                          first_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          pen_down_o,
  input  logic signed [OUT_WIDTH-1:0]   point_x_o,
  input  logic signed [OUT_WIDTH-1:0]   point_y_o,
  output int                            errors_o,
  output int                            pending_o,
  output int                            points_o
);

  typedef struct packed {
    logic                        pen;
    logic signed [OUT_WIDTH-1:0] x;
    logic signed [OUT_WIDTH-1:0] y;
  } point_t;

  localparam logic [STEP_WIDTH-1:0]  STEP_RESET  = 16'd2560;
  localparam logic [TURN_WIDTH-1:0]  TURN_RESET  = 9'd90;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

  cfg_t   cfg;
  int     heading;
  longint rel_x;
  longint rel_y;
  int     sym_count;
  int     cos_tab [FULL_TURN];
  int     sin_tab [FULL_TURN];
  point_t expected_points [$];

  // sin/cos magnitudes in Q30 by truncating series
  function automatic void taylor_q30(input longint unsigned x,
                                     output longint unsigned s_mag,
                                     output longint unsigned c_mag);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned n;
    longint          s;
    longint          c;
    bit              neg;
    x2  = (x * x) >> 30;
    t   = x;
    s   = longint'(x);
    n   = 1;
    neg = 1'b1;
    while (t != 0) begin
      t   = ((t * x2) >> 30) / ((n + 1) * (n + 2));
      n  += 2;
      s   = neg ? s - longint'(t) : s + longint'(t);
      neg = !neg;
    end
    t   = Q30_ONE;
    c   = longint'(Q30_ONE);
    n   = 0;
    neg = 1'b1;
    while (t != 0) begin
      t   = ((t * x2) >> 30) / ((n + 1) * (n + 2));
      n  += 2;
      c   = neg ? c - longint'(t) : c + longint'(t);
      neg = !neg;
    end
    s_mag = (s < 0) ? 0 : s;
    c_mag = (c < 0) ? 0 : c;
  endfunction

  function automatic int trig_q(input longint unsigned mag, input bit neg);
    longint unsigned r;
    r = (mag + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return neg ? -int'(r) : int'(r);
  endfunction

  function automatic void build_trig_tables();
    longint unsigned qs [QTAB_DEPTH];
    longint unsigned qc [QTAB_DEPTH];
    longint unsigned s;
    longint unsigned c;
    int              quad;
    int              r;
    for (int k = 0; k <= QUARTER_TURN / 2; k++) begin
      taylor_q30(longint'(k) * DEG_Q30, s, c);
      qs[k]                = s;
      qc[k]                = c;
      qs[QUARTER_TURN - k] = c;
      qc[QUARTER_TURN - k] = s;
    end
    for (int k = 0; k < FULL_TURN; k++) begin
      quad = k / QUARTER_TURN;
      r    = k % QUARTER_TURN;
      case (quad)
        0: begin
          cos_tab[k] = trig_q(qc[r], 1'b0);
          sin_tab[k] = trig_q(qs[r], 1'b0);
        end
        1: begin
          cos_tab[k] = trig_q(qs[r], 1'b1);
          sin_tab[k] = trig_q(qc[r], 1'b0);
        end
        2: begin
          cos_tab[k] = trig_q(qc[r], 1'b1);
          sin_tab[k] = trig_q(qs[r], 1'b1);
        end
        default: begin
          cos_tab[k] = trig_q(qs[r], 1'b0);
          sin_tab[k] = trig_q(qc[r], 1'b1);
        end
      endcase
    end
  endfunction

  // Q(frac+8) product to Q.8, half away from zero
  function automatic longint drop_trig_frac(input longint prod);
    longint unsigned mag;
    longint          r;
    mag = (prod < 0) ? -prod : prod;
    r   = (mag + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    return (prod < 0) ? -r : r;
  endfunction

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic point_t move_turtle(input bit backward, input bit pen);
    int     idx;
    longint dx;
    longint dy;
    point_t p;
    idx = (heading < 0) ? heading + FULL_TURN : heading;
    if (idx >= FULL_TURN || idx < 0) idx = 0;
    dx = drop_trig_frac(longint'(cos_tab[idx]) * longint'(cfg.step_length));
    dy = drop_trig_frac(longint'(sin_tab[idx]) * longint'(cfg.step_length));
    if (backward) begin
      dx = -dx;
      dy = -dy;
    end
    rel_x = saturate(rel_x + dx, POS_WIDTH);
    rel_y = saturate(rel_y + dy, POS_WIDTH);
    p.pen = pen;
    p.x   = OUT_WIDTH'(saturate(rel_x + longint'(cfg.origin_x), OUT_WIDTH));
    p.y   = OUT_WIDTH'(saturate(rel_y + longint'(cfg.origin_y), OUT_WIDTH));
    return p;
  endfunction

  // One symbol; returns 1 when it produces a point
  function automatic bit step_turtle(input logic [SYM_WIDTH-1:0] sym, input logic restart,
                                     output point_t p);
    int turn;
    bit moved;
    turn  = (cfg.turn_step > FULL_TURN) ? FULL_TURN : int'(cfg.turn_step);
    moved = 1'b0;
    p     = '0;
    if (restart) begin
      heading   = 0;
      rel_x     = 0;
      rel_y     = 0;
      sym_count = 0;
    end
    if (sym_count >= cfg.symbol_limit) return 1'b0;
    case (sym)
      SYM_PLUS: begin
        heading += turn;
        if (heading > FULL_TURN) heading -= FULL_TURN;
      end
      SYM_MINUS: begin
        heading -= turn;
        if (heading < -FULL_TURN) heading += FULL_TURN;
      end
      SYM_BAR: begin
        heading += HALF_TURN;
        if (heading > FULL_TURN) heading -= FULL_TURN;
      end
      SYM_FWD: begin
        p     = move_turtle(1'b0, 1'b1);
        moved = 1'b1;
      end
      SYM_BACK: begin
        p     = move_turtle(1'b1, 1'b1);
        moved = 1'b1;
      end
      SYM_DOT: begin
        p     = move_turtle(1'b0, 1'b0);
        moved = 1'b1;
      end
      default: ;
    endcase
    sym_count++;
    // masked letters draw forward after their own action
    if (sym != SYM_FWD && sym != SYM_BACK && sym != SYM_DOT &&
        sym[SYM_WIDTH-1:SYM_WIDTH-2] == SYM_MASK_PAGE &&
        cfg.forward_mask[sym[MASK_IDX_WIDTH-1:0]]) begin
      p     = move_turtle(1'b0, 1'b1);
      moved = 1'b1;
    end
    return moved;
  endfunction

  initial build_trig_tables();

  // Everything is stable from the falling edge to the next rising edge,
  // so a transfer is decided here without racing the block.
  always @(negedge clk_i) begin
    point_t want;
    point_t next_point;
    if (!rst_ni) begin
      cfg.step_length  = STEP_RESET;
      cfg.turn_step    = TURN_RESET;
      cfg.origin_x     = '0;
      cfg.origin_y     = '0;
      cfg.symbol_limit = LIMIT_RESET;
      cfg.forward_mask = '0;
      heading          = 0;
      rel_x            = 0;
      rel_y            = 0;
      sym_count        = 0;
      expected_points.delete();
      errors_o         = 0;
      points_o         = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_STEP_LENGTH:  cfg.step_length  = cfg_data_i[STEP_WIDTH-1:0];
          CFG_TURN_STEP:    cfg.turn_step    = cfg_data_i[TURN_WIDTH-1:0];
          CFG_ORIGIN_X:     cfg.origin_x     = cfg_data_i[ORIGIN_WIDTH-1:0];
          CFG_ORIGIN_Y:     cfg.origin_y     = cfg_data_i[ORIGIN_WIDTH-1:0];
          CFG_SYMBOL_LIMIT: cfg.symbol_limit = cfg_data_i[LIMIT_WIDTH-1:0];
          CFG_FORWARD_MASK: cfg.forward_mask = cfg_data_i[MASK_WIDTH-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        points_o++;
        if (expected_points.size() == 0) begin
          errors_o++;
          $error("point (%0d, %0d) pen %0b arrived with no move pending",
                 point_x_o, point_y_o, pen_down_o);
        end else begin
          want = expected_points.pop_front();
          if (pen_down_o !== want.pen) begin
            errors_o++;
            $error("pen_down: expected %0b, got %0b", want.pen, pen_down_o);
          end
          if (point_x_o !== want.x) begin
            errors_o++;
            $error("point_x: expected %0d, got %0d", want.x, point_x_o);
          end
          if (point_y_o !== want.y) begin
            errors_o++;
            $error("point_y: expected %0d, got %0d", want.y, point_y_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (step_turtle(symbol_i, first_i, next_point)) expected_points.push_back(next_point);
      end
    end
    pending_o = expected_points.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import tpg_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 4;
  // time for the pipe to drain, with a little margin on top
  localparam int DRAIN_CYCLES   = 10;
  localparam int LIMIT_CYCLES   = 400000;
  localparam int HOLD_CYCLES    = 100;
  localparam int PRESSURE_ITEMS = 40;

  // indexes past the last register: writes there must be dropped
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RSVD_LO = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RSVD_HI = 3'd7;

  // symbol extremes and the first code the forward mask covers
  localparam logic [SYM_WIDTH-1:0] SYM_NUL     = 8'h00;
  localparam logic [SYM_WIDTH-1:0] SYM_TOP     = 8'hFF;
  localparam logic [SYM_WIDTH-1:0] SYM_MASK_LO = 8'h40;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        cfg_we      = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]    cfg_index   = '0;
  logic [CFG_DATA_WIDTH-1:0]   cfg_data    = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic [SYM_WIDTH-1:0]        symbol      = '0;
  logic                        first       = 1'b0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic                        pen_down;
  logic signed [OUT_WIDTH-1:0] point_x;
  logic signed [OUT_WIDTH-1:0] point_y;

  int errors;
  int pending;
  int points;

  // idle odds in percent, changed between phases by the main sequence
  int tx_idle_pct  = 9;
  int rx_idle_pct  = 51;
  // long receiver hold-offs: requested by the main sequence, served below
  int hold_reqs    = 0;
  int holds_done   = 0;
  int symbols_sent = 0;
  int settings     = 0;
  int cycle_count  = 0;

  always #HALF_PERIOD clk = ~clk;

  turtle_path_generator_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .symbol_i    (symbol),
    .first_i     (first),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .pen_down_o  (pen_down),
    .point_x_o   (point_x),
    .point_y_o   (point_y)
  );

  turtle_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .symbol_i    (symbol),
    .first_i     (first),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .pen_down_o  (pen_down),
    .point_x_o   (point_x),
    .point_y_o   (point_y),
    .errors_o    (errors),
    .pending_o   (pending),
    .points_o    (points)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d points still owed", cycle_count, pending);
      $display("tb_top failed");
      $finish;
    end
  end

  // Point receiver. Random stall per cycle at the current odds, or a long
  // hold-off when the main sequence asks for one, so the pipe backs up
  // into the symbol side.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Offer one symbol, after a random gap, and hold it until the transfer.
  // Stall is looked at on the falling edge, where it is stable up to the
  // rising edge that moves the symbol.
  task automatic send_symbol(input logic [SYM_WIDTH-1:0] sym, input logic restart);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= sym;
    first    <= restart;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    symbols_sent++;
  endtask

  // Each write ends with the enable low, so it never drops and rises in one step.
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Full register set. Bits above each field get random junk, which the
  // block has to drop.
  task automatic program_turtle(input logic        [STEP_WIDTH-1:0]   step,
                                input logic        [TURN_WIDTH-1:0]   turn,
                                input logic signed [ORIGIN_WIDTH-1:0] ox,
                                input logic signed [ORIGIN_WIDTH-1:0] oy,
                                input logic        [LIMIT_WIDTH-1:0]  limit,
                                input logic        [MASK_WIDTH-1:0]   mask);
    logic [CFG_DATA_WIDTH-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_STEP_LENGTH,  {junk[CFG_DATA_WIDTH-1:STEP_WIDTH], step});
    write_reg(CFG_TURN_STEP,    {junk[CFG_DATA_WIDTH-1:TURN_WIDTH], turn});
    write_reg(CFG_ORIGIN_X,     {junk[CFG_DATA_WIDTH-1:ORIGIN_WIDTH], ox});
    write_reg(CFG_ORIGIN_Y,     {junk[CFG_DATA_WIDTH-1:ORIGIN_WIDTH], oy});
    write_reg(CFG_SYMBOL_LIMIT, {junk[CFG_DATA_WIDTH-1:LIMIT_WIDTH], limit});
    write_reg(CFG_FORWARD_MASK, mask);
    settings++;
  endtask

  // Stop offering, collect every owed point, then let symbols that make
  // no point clear the pipe before any register changes.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly turtle commands, then letters the forward mask may pick up,
  // then any byte at all.
  function automatic logic [SYM_WIDTH-1:0] pick_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      case ($urandom_range(5))
        0:       return SYM_FWD;
        1:       return SYM_BACK;
        2:       return SYM_DOT;
        3:       return SYM_PLUS;
        4:       return SYM_MINUS;
        default: return SYM_BAR;
      endcase
    end
    if (r < 85) return SYM_MASK_LO + SYM_WIDTH'($urandom_range(63));
    return SYM_WIDTH'($urandom_range(255));
  endfunction

  // Random strings, almost all opened with the restart flag; a few open
  // without it or restart halfway through.
  task automatic run_strings(input int count);
    int   left;
    int   len;
    logic restart;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len && left > 0; i++) begin
        restart = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(24) == 0);
        send_symbol(pick_symbol(), restart);
        left--;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- Directed, reset settings: step 10.0, turn 90 ---
    send_symbol(SYM_FWD,   1'b1);
    send_symbol(SYM_PLUS,  1'b0);
    send_symbol(SYM_FWD,   1'b0);
    send_symbol(SYM_PLUS,  1'b0);
    send_symbol(SYM_BACK,  1'b0);
    send_symbol(SYM_PLUS,  1'b0);
    send_symbol(SYM_DOT,   1'b0);
    // heading reaches exactly 360, which must map to table entry zero
    send_symbol(SYM_PLUS,  1'b0);
    send_symbol(SYM_FWD,   1'b0);
    // past 360 wraps down, for a turn and for the half turn
    send_symbol(SYM_PLUS,  1'b0);
    send_symbol(SYM_BAR,   1'b0);
    send_symbol(SYM_BAR,   1'b0);
    // negative headings down to -360 and the wrap below it
    send_symbol(SYM_MINUS, 1'b1);
    send_symbol(SYM_FWD,   1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_FWD,   1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    // unknown bytes and an unmasked letter: counted, nothing drawn
    send_symbol(SYM_NUL,     1'b0);
    send_symbol(SYM_TOP,     1'b0);
    send_symbol(SYM_MASK_LO, 1'b0);
    send_symbol(SYM_BAR,     1'b1);
    send_symbol(SYM_BACK,    1'b0);

    // --- Sender rarely idle, receiver stalls about half the time ---
    // Longest step, full turn, every letter draws, origins at the rails
    // so the emitted point saturates.
    settle();
    program_turtle(16'hFFFF, 9'd360, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, '1);
    run_strings(100);

    // Zero everywhere, limit zero: every symbol is dropped. The two
    // unused indexes get all ones and must change nothing.
    settle();
    program_turtle('0, '0, '0, '0, '0, '0);
    write_reg(CFG_RSVD_LO, '1);
    write_reg(CFG_RSVD_HI, '1);
    run_strings(20);

    // Short symbol limit so most strings run into it
    settle();
    program_turtle(STEP_WIDTH'($urandom), 9'd45, $urandom, $urandom, 16'd7,
                   {$urandom, $urandom});
    run_strings(120);

    // --- Roles swapped ---
    // Turn register at its top code, which must act as a full turn
    settle();
    tx_idle_pct = 51;
    rx_idle_pct = 9;
    program_turtle(STEP_WIDTH'($urandom), '1, $urandom, $urandom, 16'hFFFF,
                   {$urandom, $urandom});
    run_strings(120);

    // Origins at the opposite rails; mask holds the lowest letter and the
    // half-turn bar, which turns and then draws
    settle();
    program_turtle(16'hFFFF, 9'd30, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd20,
                   (64'd1 << (SYM_BAR - SYM_MASK_LO)) | 64'd1);
    run_strings(120);

    // --- No idling on either side ---
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_turtle(16'd256, 9'd90, $urandom, $urandom, 16'hFFFF, {$urandom, $urandom});
    run_strings(60);

    // Receiver holds off while symbols keep coming: the pipe fills and
    // the symbol side must stall without losing a transfer.
    hold_reqs++;
    send_symbol(SYM_FWD, 1'b1);
    for (int i = 1; i < PRESSURE_ITEMS; i++) send_symbol(SYM_FWD, 1'b0);
    run_strings(60);

    // Sender goes quiet until every owed point is out, then resumes
    settle();
    run_strings(60);

    settle();
    $display("covered %0d symbols over %0d register sets, %0d points compared,",
             symbols_sent, settings, points);
    $display("with both idle mixes, a no-idle stretch and %0d long output hold-offs",
             holds_done);
    if (errors == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* turtle_path_generator_top.f */
hw/rtl/tpg_pkg.sv
hw/rtl/tpg_ctrl.sv
hw/rtl/tpg_trig.sv
hw/rtl/tpg_move.sv
hw/rtl/turtle_path_generator_top.sv
tb/turtle_checker.sv
tb/tb_top.sv
